### hdl/fba_pkg.sv
// Shared types and constants for the frame bitmap allocator.
// No dependencies; fba_req_if, fba_rsp_if and the core import this package.
`timescale 1ns / 1ps

package fba_pkg;

    localparam int REQ_W    = 2;
    localparam int FRAME_W  = 10;
    localparam int STATUS_W = 3;
    localparam int CFG_W    = 11;

    localparam logic [CFG_W-1:0] CFG_RESET = 11'd1024;

    typedef logic [REQ_W-1:0]    t_req_type;
    typedef logic [STATUS_W-1:0] t_status;

    localparam t_req_type REQ_ALLOC = 2'd0;
    localparam t_req_type REQ_FREE  = 2'd1;
    localparam t_req_type REQ_TEST  = 2'd2;

    localparam t_status ST_ALLOCATED = 3'd0;
    localparam t_status ST_MAPPED    = 3'd1;
    localparam t_status ST_NO_FRAME  = 3'd2;
    localparam t_status ST_FREED     = 3'd3;
    localparam t_status ST_NOTHING   = 3'd4;
    localparam t_status ST_TESTED    = 3'd5;

    typedef struct packed {
        t_status              status;
        logic [FRAME_W-1:0]   frame_out;
        logic                 bit_is_set;
        logic                 entry_present;
        logic                 entry_writable;
        logic                 entry_user;
    } t_rsp;

endpackage

### hdl/fba_req_if.sv
// Request channel: valid/ready handshake with the request payload.
// Depends on fba_pkg.
`timescale 1ns / 1ps

interface fba_req_if
    import fba_pkg::*;
();
    logic               valid;
    logic               ready;
    t_req_type          req_type;
    logic [FRAME_W-1:0] frame_index;
    logic               user_page;
    logic               writable_page;

    modport source (output valid, req_type, frame_index, user_page, writable_page,
                    input ready);
    modport sink   (input valid, req_type, frame_index, user_page, writable_page,
                    output ready);
endinterface

### hdl/fba_rsp_if.sv
// Result channel: valid/ready handshake with the result payload.
// Depends on fba_pkg.
`timescale 1ns / 1ps

interface fba_rsp_if
    import fba_pkg::*;
();
    logic               valid;
    logic               ready;
    t_status            status;
    logic [FRAME_W-1:0] frame_out;
    logic               bit_is_set;
    logic               entry_present;
    logic               entry_writable;
    logic               entry_user;

    modport source (output valid, status, frame_out, bit_is_set, entry_present,
                    entry_writable, entry_user, input ready);
    modport sink   (input valid, status, frame_out, bit_is_set, entry_present,
                    entry_writable, entry_user, output ready);
endinterface

### hdl/fba_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps

module fba_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                i_clk,
    input  logic                i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]    i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]    o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

### hdl/frame_bitmap_allocator_core.sv
// Frame bitmap allocator, first fit: top level with the control sequencer.
// Depends on fba_pkg, fba_req_if, fba_rsp_if and fba_ram.
`timescale 1ns / 1ps
//
// Usage:
//   i_req  (sink): one request per transfer: allocate, free or test a frame.
//   o_rsp  (source): exactly one result per request, in request order.
//   i_cfg_we / i_cfg_wdata: write frame_count; write only while the block is idle.
//   The used bitmap sits in one RAM of WORD_BITS-wide words, with a registered read.
// Steps from request transfer to the result register:
//   already mapped, nothing to free, frame limit of zero, out-of-range index: straight on.
//   free and test of a frame in range: address, read, modify/write (the write for free only).
//   allocate: words scanned one word per cycle through the RAM read port, up to
//   WORD_COUNT words.
// One request is in work at a time; i_req.ready is high only between requests.
// A finished result waits in the output register while the next request is taken.
// Reset: a clearing pass writes zero to every word; i_req.ready stays low until it
//   ends. frame_count resets to 1024.
// When the receiver stalls, the result holds and the next result waits inside.

module frame_bitmap_allocator_core
    import fba_pkg::*;
#(
    parameter int NUM_FRAMES = 1024,
    parameter int WORD_BITS  = 32
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [CFG_W-1:0] i_cfg_wdata,
    fba_req_if.sink          i_req,
    fba_rsp_if.source        o_rsp
);

    localparam int WORD_COUNT = (NUM_FRAMES + WORD_BITS - 1) / WORD_BITS;
    localparam int AW         = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
    localparam int BW         = $clog2(WORD_BITS);
    localparam int CNT_W      = $clog2(NUM_FRAMES + 1);
    localparam int LW         = (CNT_W > CFG_W) ? CNT_W : CFG_W;
    localparam int DIV_SH     = 20;
    localparam int PW         = FRAME_W + DIV_SH;
    localparam int RECIP      = ((1 << DIV_SH) + WORD_BITS - 1) / WORD_BITS;

    localparam logic [AW-1:0] LAST_ADDR = AW'(WORD_COUNT - 1);
    localparam logic [LW-1:0] NUM_L     = LW'(NUM_FRAMES);
    localparam logic [LW-1:0] WB_L      = LW'(WORD_BITS);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_DIV,
        S_RD,
        S_RMW,
        S_SCAN,
        S_DONE
    } t_state;

    t_state             r_state;
    logic [CFG_W-1:0]   r_frame_count;
    logic [AW-1:0]      r_addr;
    logic [BW-1:0]      r_bit;
    logic [FRAME_W-1:0] r_fidx;
    logic [FRAME_W-1:0] r_q;
    logic [LW-1:0]      r_base;
    logic [LW-1:0]      r_remain;
    logic               r_free;
    logic               r_user;
    logic               r_wr;
    t_rsp               r_res;
    t_rsp               r_out;
    logic               r_out_valid;

    logic [LW-1:0]        w_limit;
    logic                 w_accept;
    logic                 w_out_room;
    logic [PW-1:0]        w_prod;
    logic [FRAME_W-1:0]   w_rem;
    logic                 w_idx_oob;
    logic [WORD_BITS-1:0] w_rdata;
    logic [WORD_BITS-1:0] w_bit_mask;
    logic [WORD_BITS-1:0] w_free_bits;
    logic [BW-1:0]        w_idx;
    logic                 w_found;
    logic                 w_last;
    logic [LW-1:0]        w_got;
    logic                 w_we;
    logic [AW-1:0]        w_waddr;
    logic [WORD_BITS-1:0] w_wdata;
    logic [AW-1:0]        w_raddr;

    fba_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (WORD_COUNT)
    ) u_bitmap (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    assign w_limit    = (LW'(r_frame_count) > NUM_L) ? NUM_L : LW'(r_frame_count);
    assign w_accept   = i_req.valid && i_req.ready;
    assign w_out_room = !r_out_valid || o_rsp.ready;
    assign w_idx_oob  = LW'(i_req.frame_index) >= NUM_L;
    assign w_prod     = PW'(r_fidx) * PW'(RECIP);
    assign w_rem      = r_fidx - FRAME_W'(r_q * FRAME_W'(WORD_BITS));
    assign w_bit_mask = {{(WORD_BITS-1){1'b0}}, 1'b1} << r_bit;

    always_comb begin
        for (int b = 0; b < WORD_BITS; b++) begin
            w_free_bits[b] = !w_rdata[b] && (LW'(b) < r_remain);
        end
        w_idx = '0;
        for (int b = WORD_BITS - 1; b >= 0; b--) begin
            if (w_free_bits[b]) begin
                w_idx = BW'(b);
            end
        end
    end

    assign w_found = |w_free_bits;
    assign w_last  = (r_addr == LAST_ADDR) || (r_remain <= WB_L);
    assign w_got   = r_base + LW'(w_idx);

    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_addr;
        w_wdata = '0;
        w_raddr = r_addr;
        case (r_state)
            S_CLEAR: begin
                w_we = 1'b1;
            end
            S_IDLE: begin
                w_raddr = '0;
            end
            S_RMW: begin
                w_we    = r_free;
                w_wdata = w_rdata & ~w_bit_mask;
            end
            S_SCAN: begin
                w_we    = w_found;
                w_wdata = w_rdata | ({{(WORD_BITS-1){1'b0}}, 1'b1} << w_idx);
                w_raddr = r_addr + AW'(1);
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_CLEAR;
            r_addr        <= '0;
            r_frame_count <= CFG_RESET;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_frame_count <= i_cfg_wdata;
            end
            if (r_out_valid && o_rsp.ready && (r_state != S_DONE)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_CLEAR: begin
                    if (r_addr == LAST_ADDR) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_addr <= r_addr + AW'(1);
                    end
                end
                S_IDLE: begin
                    if (w_accept) begin
                        r_res.frame_out      <= '0;
                        r_res.bit_is_set     <= 1'b0;
                        r_res.entry_present  <= 1'b0;
                        r_res.entry_writable <= 1'b0;
                        r_res.entry_user     <= 1'b0;
                        r_fidx  <= i_req.frame_index;
                        r_user  <= i_req.user_page;
                        r_wr    <= i_req.writable_page;
                        r_free  <= (i_req.req_type == REQ_FREE);
                        if (i_req.req_type == REQ_ALLOC) begin
                            if (i_req.frame_index != '0) begin
                                r_res.status <= ST_MAPPED;
                                r_state      <= S_DONE;
                            end else if (w_limit == '0) begin
                                r_res.status <= ST_NO_FRAME;
                                r_state      <= S_DONE;
                            end else begin
                                r_addr   <= '0;
                                r_base   <= '0;
                                r_remain <= w_limit;
                                r_state  <= S_SCAN;
                            end
                        end else if (i_req.req_type == REQ_FREE) begin
                            if (i_req.frame_index == '0) begin
                                r_res.status <= ST_NOTHING;
                                r_state      <= S_DONE;
                            end else begin
                                r_res.status <= ST_FREED;
                                r_state      <= w_idx_oob ? S_DONE : S_DIV;
                            end
                        end else begin
                            r_res.status <= ST_TESTED;
                            r_state      <= w_idx_oob ? S_DONE : S_DIV;
                        end
                    end
                end
                S_DIV: begin
                    r_q     <= w_prod[PW-1:DIV_SH];
                    r_addr  <= AW'(w_prod[PW-1:DIV_SH]);
                    r_state <= S_RD;
                end
                S_RD: begin
                    r_bit   <= BW'(w_rem);
                    r_state <= S_RMW;
                end
                S_RMW: begin
                    r_res.bit_is_set <= !r_free && |(w_rdata & w_bit_mask);
                    r_state          <= S_DONE;
                end
                S_SCAN: begin
                    if (w_found) begin
                        r_res.status         <= ST_ALLOCATED;
                        r_res.frame_out      <= FRAME_W'(w_got);
                        r_res.entry_present  <= 1'b1;
                        r_res.entry_writable <= r_wr;
                        r_res.entry_user     <= r_user;
                        r_state              <= S_DONE;
                    end else if (w_last) begin
                        r_res.status <= ST_NO_FRAME;
                        r_state      <= S_DONE;
                    end else begin
                        r_addr   <= r_addr + AW'(1);
                        r_base   <= r_base + WB_L;
                        r_remain <= r_remain - WB_L;
                    end
                end
                S_DONE: begin
                    if (w_out_room) begin
                        r_out       <= r_res;
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign i_req.ready          = (r_state == S_IDLE);
    assign o_rsp.valid          = r_out_valid;
    assign o_rsp.status         = r_out.status;
    assign o_rsp.frame_out      = r_out.frame_out;
    assign o_rsp.bit_is_set     = r_out.bit_is_set;
    assign o_rsp.entry_present  = r_out.entry_present;
    assign o_rsp.entry_writable = r_out.entry_writable;
    assign o_rsp.entry_user     = r_out.entry_user;

    a_accept_drops_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> !i_req.ready)
        else $error("request taken while a request is in work");

    a_scan_has_frames: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_remain != '0))
        else $error("scan running past the frame limit");

    a_scan_addr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_addr <= LAST_ADDR))
        else $error("scan address beyond the bitmap");

    a_present_only_alloc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out.status != ST_ALLOCATED)) |-> !r_out.entry_present)
        else $error("entry present without an allocation");

endmodule

### dv/fba_checker.sv
// Scoreboard for the frame bitmap allocator: watches config writes and both channels,
// keeps its own used-frame bitmap and compares each result with the oldest prediction.
// Depends on fba_pkg, fba_req_if and fba_rsp_if.
`timescale 1ns / 1ps

module fba_checker
    import fba_pkg::*;
#(
    parameter int NUM_FRAMES = 1024
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [CFG_W-1:0] i_cfg_wdata,
    fba_req_if               i_req,
    fba_rsp_if               i_rsp,
    output int               o_pending,
    output int               o_fail_count
);

    t_rsp                  expected_rsp_q[$];
    logic [NUM_FRAMES-1:0] used_map;
    logic [CFG_W-1:0]      frame_limit;
    int                    fails = 0;

    assign o_fail_count = fails;

    // Serve one request against the local bitmap; return the result it must produce.
    function automatic t_rsp serve_request(input t_req_type kind,
                                           input logic [FRAME_W-1:0] idx,
                                           input logic user, input logic wr);
        t_rsp r;
        int   span;
        int   f;
        logic found;
        r = '0;
        found = 1'b0;
        case (kind)
            REQ_ALLOC: begin
                if (idx != '0) begin
                    r.status = ST_MAPPED;
                end else begin
                    span = (int'(frame_limit) > NUM_FRAMES) ? NUM_FRAMES : int'(frame_limit);
                    r.status = ST_NO_FRAME;
                    for (f = 0; f < span && !found; f++) begin
                        if (!used_map[f]) begin
                            found = 1'b1;
                            used_map[f] = 1'b1;
                            r.status = ST_ALLOCATED;
                            r.frame_out = f[FRAME_W-1:0];
                            r.entry_present = 1'b1;
                            r.entry_writable = wr;
                            r.entry_user = user;
                        end
                    end
                end
            end
            REQ_FREE: begin
                if (idx == '0) begin
                    r.status = ST_NOTHING;
                end else begin
                    if (int'(idx) < NUM_FRAMES) used_map[idx] = 1'b0;
                    r.status = ST_FREED;
                end
            end
            default: begin
                r.status = ST_TESTED;
                r.bit_is_set = (int'(idx) < NUM_FRAMES) ? used_map[idx] : 1'b0;
            end
        endcase
        return r;
    endfunction

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned seen);
        if (want != seen) begin
            $error("%s mismatch: expected %0d, got %0d", name, want, seen);
            fails++;
        end
    endtask

    always @(posedge i_clk) begin : monitor
        t_rsp want;
        if (!i_rst_n) begin
            used_map = '0;
            frame_limit = CFG_RESET;
            expected_rsp_q.delete();
        end else begin
            if (i_cfg_we) frame_limit = i_cfg_wdata;
            if (i_rsp.valid && i_rsp.ready) begin
                if (expected_rsp_q.size() == 0) begin
                    $error("result transfer with no request outstanding (status %0d)",
                           i_rsp.status);
                    fails++;
                end else begin
                    want = expected_rsp_q.pop_front();
                    check_field("status", want.status, i_rsp.status);
                    check_field("frame_out", want.frame_out, i_rsp.frame_out);
                    check_field("bit_is_set", want.bit_is_set, i_rsp.bit_is_set);
                    check_field("entry_present", want.entry_present, i_rsp.entry_present);
                    check_field("entry_writable", want.entry_writable, i_rsp.entry_writable);
                    check_field("entry_user", want.entry_user, i_rsp.entry_user);
                end
            end
            if (i_req.valid && i_req.ready) begin
                expected_rsp_q.push_back(serve_request(i_req.req_type, i_req.frame_index,
                                                       i_req.user_page,
                                                       i_req.writable_page));
            end
        end
        o_pending <= expected_rsp_q.size();
    end

endmodule

### dv/tb.sv
// Testbench top for frame_bitmap_allocator_core: clock, reset, request stimulus,
// result-side stalls, frame_count phases and the verdict; fba_checker does the checking.
// Depends on fba_pkg, fba_req_if, fba_rsp_if, fba_checker and the block under test.
`timescale 1ns / 1ps

module tb;
    import fba_pkg::*;

    localparam int        HALF_PERIOD  = 2;
    localparam int        RESET_CYCLES = 7;
    localparam int        CYCLE_LIMIT  = 1_500_000;
    localparam int        LONG_HOLD    = 300;
    localparam int        HOLD_SPACING = 5000;
    localparam int        TAIL_CYCLES  = 60;
    localparam t_req_type REQ_SPARE    = 2'd3;

    logic             i_clk = 1'b0;
    logic             i_rst_n;
    logic             cfg_we;
    logic [CFG_W-1:0] cfg_wdata;
    int               pending;
    int               fail_count;
    int               cycles = 0;
    int               tight_left = 0;
    int               n_alloc = 0;
    int               n_free = 0;
    int               n_test = 0;
    int               n_settings = 0;

    fba_req_if req_ch ();
    fba_rsp_if rsp_ch ();

    always #(HALF_PERIOD) i_clk = ~i_clk;

    frame_bitmap_allocator_core DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_req       (req_ch),
        .o_rsp       (rsp_ch)
    );

    fba_checker #(.NUM_FRAMES(1024)) u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_wdata  (cfg_wdata),
        .i_req        (req_ch),
        .i_rsp        (rsp_ch),
        .o_pending    (pending),
        .o_fail_count (fail_count)
    );

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic send_req(input t_req_type kind, input logic [FRAME_W-1:0] idx,
                            input logic user, input logic wr);
        int gap;
        gap = (tight_left > 0) ? 0 : gap_len();
        if (tight_left > 0) tight_left--;
        if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.req_type <= kind;
        req_ch.frame_index <= idx;
        req_ch.user_page <= user;
        req_ch.writable_page <= wr;
        do @(posedge i_clk); while (!req_ch.ready);
        case (kind)
            REQ_ALLOC: n_alloc++;
            REQ_FREE:  n_free++;
            default:   n_test++;
        endcase
    endtask

    // Hold the request side until every outstanding result has been taken.
    task automatic wait_idle();
        req_ch.valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (2) @(posedge i_clk);
    endtask

    task automatic set_frame_count(input logic [CFG_W-1:0] value);
        wait_idle();
        cfg_we <= 1'b1;
        cfg_wdata <= value;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        n_settings++;
    endtask

    task automatic run_random(input int count, input int alloc_pct, input int free_pct,
                              input int idx_max);
        int               r;
        t_req_type        kind;
        logic [FRAME_W-1:0] idx;
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(0, 79) == 0) wait_idle();
            if ($urandom_range(0, 99) == 0) tight_left = $urandom_range(20, 60);
            r = $urandom_range(0, 99);
            if (r < alloc_pct) begin
                kind = REQ_ALLOC;
                idx = ($urandom_range(0, 9) == 0) ? FRAME_W'($urandom_range(1, 1023)) : '0;
            end else if (r < alloc_pct + free_pct) begin
                kind = REQ_FREE;
                idx = FRAME_W'($urandom_range(0, idx_max));
            end else begin
                kind = ($urandom_range(0, 3) == 0) ? REQ_SPARE : REQ_TEST;
                idx = ($urandom_range(0, 4) == 0) ? FRAME_W'($urandom_range(0, 1023))
                                                  : FRAME_W'($urandom_range(0, idx_max));
            end
            send_req(kind, idx, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        end
    endtask

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("tb: FAIL");
            $finish;
        end
    end

    initial begin : result_sink
        int hold;
        int run;
        int since_long;
        rsp_ch.ready <= 1'b0;
        since_long = 0;
        forever begin
            if (since_long >= HOLD_SPACING) begin
                rsp_ch.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
                since_long = 0;
            end
            hold = gap_len();
            if (hold > 0) begin
                rsp_ch.ready <= 1'b0;
                repeat (hold) @(posedge i_clk);
                since_long += hold;
            end
            rsp_ch.ready <= 1'b1;
            run = ($urandom_range(0, 19) == 0) ? $urandom_range(50, 200)
                                               : $urandom_range(1, 8);
            repeat (run) @(posedge i_clk);
            since_long += run;
        end
    end

    initial begin : stimulus
        i_rst_n <= 1'b0;
        cfg_we <= 1'b0;
        cfg_wdata <= '0;
        req_ch.valid <= 1'b0;
        req_ch.req_type <= REQ_ALLOC;
        req_ch.frame_index <= '0;
        req_ch.user_page <= 1'b0;
        req_ch.writable_page <= 1'b0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_req(REQ_TEST,  10'd0,    1'b0, 1'b0);
        send_req(REQ_ALLOC, 10'd5,    1'b1, 1'b1);
        send_req(REQ_FREE,  10'd0,    1'b0, 1'b0);
        send_req(REQ_ALLOC, 10'd0,    1'b1, 1'b0);
        send_req(REQ_ALLOC, 10'd0,    1'b0, 1'b1);
        send_req(REQ_ALLOC, 10'd0,    1'b1, 1'b1);
        send_req(REQ_TEST,  10'd0,    1'b0, 1'b0);
        send_req(REQ_SPARE, 10'd1,    1'b0, 1'b0);
        send_req(REQ_FREE,  10'd1023, 1'b0, 1'b0);
        send_req(REQ_TEST,  10'd1023, 1'b1, 1'b1);
        send_req(REQ_FREE,  10'd1,    1'b0, 1'b0);
        send_req(REQ_SPARE, 10'd1,    1'b0, 1'b0);
        send_req(REQ_ALLOC, 10'd0,    1'b0, 1'b0);
        send_req(REQ_ALLOC, 10'd1023, 1'b0, 1'b0);
        send_req(REQ_FREE,  10'd1023, 1'b1, 1'b1);
        send_req(REQ_TEST,  10'h2AA,  1'b0, 1'b0);
        send_req(REQ_TEST,  10'h155,  1'b0, 1'b0);

        set_frame_count(11'd0);
        send_req(REQ_ALLOC, 10'd0, 1'b1, 1'b1);
        send_req(REQ_TEST,  10'd0, 1'b0, 1'b0);
        run_random(40, 60, 20, 63);

        set_frame_count(11'd1);
        send_req(REQ_ALLOC, 10'd0, 1'b1, 1'b0);
        run_random(40, 60, 20, 7);

        set_frame_count(11'd40);
        run_random(400, 50, 30, 63);

        set_frame_count(11'd2047);
        run_random(1200, 95, 3, 1023);

        set_frame_count(11'd1023);
        run_random(150, 50, 30, 1023);

        set_frame_count(11'd1024);
        run_random(100, 50, 30, 1023);

        wait_idle();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("tb: %0d requests: %0d allocate, %0d free, %0d test (incl. spare code)",
                 n_alloc + n_free + n_test, n_alloc, n_free, n_test);
        $display("tb: %0d frame_count writes, from 0 up to 2047, bitmap filled to capacity",
                 n_settings);
        if (fail_count == 0) begin
            $display("tb: PASS");
        end else begin
            $display("tb: FAIL");
        end
        $finish;
    end

endmodule
